@@ rtl/hbsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsa_pkg
// Shared constants, derived widths and controller/datapath bundles for the
// hashed bucket slot allocator.
// ----------------------------------------------------------------------------
package hbsa_pkg;

   // table geometry
   localparam int BUCKET_COUNT     = 40;
   localparam int SLOTS_PER_BUCKET = 28;

   // hash: home = (HASH_MUL * (key mod HASH_MOD)) mod BUCKET_COUNT
   localparam int HASH_MUL = 42;
   localparam int HASH_MOD = 997;

   // item field widths
   localparam int KEY_W        = 26;
   localparam int BUCKET_IDX_W = 6;
   localparam int SLOT_IDX_W   = 5;

   // internal widths
   localparam int B_W     = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int SI_W    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int CNT_W   = $clog2(BUCKET_COUNT + 1);
   localparam int OCC_W   = SLOTS_PER_BUCKET + 1;
   localparam int KADDR_W = $clog2(BUCKET_COUNT * SLOTS_PER_BUCKET);

   // remainder unit: key mod HASH_MOD by folding the upper key bits
   // (2**FOLD_W == FOLD_MUL mod HASH_MOD), then mod BUCKET_COUNT by
   // reciprocal multiplication
   localparam int HR_W       = $clog2(HASH_MOD);
   localparam int MUL_W      = $clog2(HASH_MUL + 1);
   localparam int PROD_W     = HR_W + MUL_W;
   localparam int FOLD_W     = HR_W;
   localparam int FOLD_MUL   = (2 ** FOLD_W) % HASH_MOD;
   // four folds bring a 26-bit key below 2 * HASH_MOD
   localparam int FOLD_STEPS = 4;
   localparam int SH_W       = $clog2(FOLD_STEPS + 1);
   localparam int RECIP_SH   = 24;
   localparam int RECIP_M    = (2 ** RECIP_SH + BUCKET_COUNT - 1) / BUCKET_COUNT;
   localparam int RECIP_W    = $clog2(RECIP_M + 1);
   localparam int QPROD_W    = PROD_W + RECIP_W;
   localparam int Q_W        = QPROD_W - RECIP_SH;

   typedef struct packed {
      logic load;        // capture request, start key mod HASH_MOD
      logic mod_step;    // one remainder step
      logic mul;         // remainder times HASH_MUL, start mod BUCKET_COUNT
      logic probe_init;  // point the probe at the home bucket
      logic probe_adv;   // read next bucket, shift check stage
      logic commit;      // write table on a hit, load result register
   } cmd_type;

   typedef struct packed {
      logic mod_last;    // current remainder step is the last one
      logic chk_live;    // check stage holds a bucket's occupancy
      logic hit;         // checked bucket accepts the entry
      logic last;        // every bucket has been read
   } sts_type;

endpackage

@@ rtl/hbsa_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsa_if
// Valid/ready channels for requests and responses of the slot allocator.
// ----------------------------------------------------------------------------
interface hbsa_req_if import hbsa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             opcode;
   logic [KEY_W-1:0] entry_key;
   logic [KEY_W-1:0] companion_key;

   modport source (output valid, opcode, entry_key, companion_key, input ready);
   modport sink   (input valid, opcode, entry_key, companion_key, output ready);
endinterface

interface hbsa_rsp_if import hbsa_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [BUCKET_IDX_W-1:0] bucket_index;
   logic [SLOT_IDX_W-1:0]   slot_index;
   logic                    table_full;

   modport source (output valid, bucket_index, slot_index, table_full, input ready);
   modport sink   (input valid, bucket_index, slot_index, table_full, output ready);
endinterface

@@ rtl/hbsa_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsa_datapath
// Hash remainder unit, bucket occupancy memory with probe pipeline, key
// stores and the result register.
// ----------------------------------------------------------------------------
module hbsa_datapath import hbsa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   input  logic                    in_opcode,
   input  logic [KEY_W-1:0]        in_entry_key,
   input  logic [KEY_W-1:0]        in_companion_key,
   output logic [BUCKET_IDX_W-1:0] out_bucket_index,
   output logic [SLOT_IDX_W-1:0]   out_slot_index,
   output logic                    out_table_full
);

   // captured request
   logic             op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] ckey_ff;

   // remainder unit
   logic [KEY_W-1:0]   rem_ff, rem_in;
   logic [SH_W-1:0]    sh_ff;
   logic               div_sel_ff;
   logic [Q_W-1:0]     q_ff;
   logic [KEY_W-1:0]   fold;
   logic [KEY_W-1:0]   csub;
   logic [QPROD_W-1:0] qprod;
   logic [PROD_W-1:0]  prod;

   // probe pipeline
   logic [B_W-1:0]   rd_addr_ff, rd_addr_in;
   logic [B_W-1:0]   chk_addr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             chk_live_ff;
   logic [OCC_W-1:0] rd_data_ff;
   logic             rd_valid_ff;

   // storage
   logic [BUCKET_COUNT-1:0] valid_ff;
   logic [OCC_W-1:0]        occ_mem  [BUCKET_COUNT];
   logic [KEY_W-1:0]        key_mem  [BUCKET_COUNT * SLOTS_PER_BUCKET];
   logic [KEY_W-1:0]        comp_mem [BUCKET_COUNT];

   // check stage
   logic [SLOTS_PER_BUCKET-1:0] used;
   logic [SLOTS_PER_BUCKET-1:0] free_bits;
   logic [SLOTS_PER_BUCKET-1:0] low_free;
   logic                        comp_used;
   logic [SI_W-1:0]             free_idx;
   logic                        hit;
   logic [KADDR_W-1:0]          key_addr;

   // result register
   logic [BUCKET_IDX_W-1:0] res_bucket_ff;
   logic [SLOT_IDX_W-1:0]   res_slot_ff;
   logic                    res_full_ff;

   // hi * 2**FOLD_W + lo == hi * FOLD_MUL + lo (mod HASH_MOD)
   assign fold  = KEY_W'(rem_ff[KEY_W-1:FOLD_W]) * KEY_W'(FOLD_MUL)
                + KEY_W'(rem_ff[FOLD_W-1:0]);
   assign csub  = (rem_ff >= KEY_W'(HASH_MOD)) ? rem_ff - KEY_W'(HASH_MOD) : rem_ff;
   assign qprod = QPROD_W'(rem_ff[PROD_W-1:0]) * QPROD_W'(RECIP_M);
   assign prod  = PROD_W'(rem_ff[HR_W-1:0]) * PROD_W'(HASH_MUL);

   // first pass: folds, then one compare and subtract
   // second pass: quotient by reciprocal, then remainder
   always_comb begin
      if (!div_sel_ff) begin
         rem_in = (sh_ff != '0) ? fold : csub;
      end else begin
         rem_in = (sh_ff != '0) ? rem_ff : rem_ff - KEY_W'(q_ff) * KEY_W'(BUCKET_COUNT);
      end
   end

   assign rd_addr_in = (rd_addr_ff == B_W'(BUCKET_COUNT - 1)) ? '0 : rd_addr_ff + 1'b1;

   // never-written buckets read as empty
   assign used      = rd_valid_ff ? rd_data_ff[SLOTS_PER_BUCKET-1:0] : '0;
   assign comp_used = rd_valid_ff & rd_data_ff[SLOTS_PER_BUCKET];
   assign free_bits = ~used;
   assign low_free  = free_bits & (~free_bits + 1'b1);

   always_comb begin
      free_idx = '0;
      for (int j = 0; j < SLOTS_PER_BUCKET; j++) begin
         if (low_free[j]) begin
            free_idx = free_idx | SI_W'(j);
         end
      end
   end

   assign hit = chk_live_ff && (|free_bits) && (!op_ff || !comp_used);

   assign key_addr = KADDR_W'(chk_addr_ff) * KADDR_W'(SLOTS_PER_BUCKET) + KADDR_W'(free_idx);

   assign sts.mod_last = (sh_ff == '0);
   assign sts.chk_live = chk_live_ff;
   assign sts.hit      = hit;
   assign sts.last     = (cnt_ff == CNT_W'(BUCKET_COUNT));

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_live_ff <= 1'b0;
         valid_ff    <= '0;
      end else begin
         if (cmd.probe_init) begin
            chk_live_ff <= 1'b0;
         end else if (cmd.probe_adv) begin
            chk_live_ff <= 1'b1;
         end
         if (cmd.commit && hit) begin
            valid_ff[chk_addr_ff] <= 1'b1;
         end
      end
   end

   // request capture, remainder unit and probe pointers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= in_opcode;
         key_ff     <= in_entry_key;
         ckey_ff    <= in_companion_key;
         rem_ff     <= in_entry_key;
         sh_ff      <= SH_W'(FOLD_STEPS);
         div_sel_ff <= 1'b0;
      end else if (cmd.mul) begin
         rem_ff     <= KEY_W'(prod);
         sh_ff      <= SH_W'(1);
         div_sel_ff <= 1'b1;
      end else if (cmd.mod_step) begin
         rem_ff <= rem_in;
         q_ff   <= qprod[QPROD_W-1:RECIP_SH];
         sh_ff  <= sh_ff - 1'b1;
      end
      if (cmd.probe_init) begin
         rd_addr_ff <= rem_ff[B_W-1:0];
         cnt_ff     <= '0;
      end else if (cmd.probe_adv) begin
         rd_addr_ff  <= rd_addr_in;
         chk_addr_ff <= rd_addr_ff;
         cnt_ff      <= cnt_ff + 1'b1;
         rd_valid_ff <= valid_ff[rd_addr_ff];
      end
   end

   // occupancy memory: one registered read port, one write port
   always_ff @(posedge clock) begin
      if (cmd.probe_adv) begin
         rd_data_ff <= occ_mem[rd_addr_ff];
      end
      if (cmd.commit && hit) begin
         occ_mem[chk_addr_ff] <= {comp_used | op_ff, used | low_free};
      end
   end

   // key stores
   always_ff @(posedge clock) begin
      if (cmd.commit && hit) begin
         key_mem[key_addr] <= key_ff;
         if (op_ff) begin
            comp_mem[chk_addr_ff] <= ckey_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         res_bucket_ff <= hit ? BUCKET_IDX_W'(chk_addr_ff) : '0;
         res_slot_ff   <= hit ? SLOT_IDX_W'(free_idx) : '0;
         res_full_ff   <= !hit;
      end
   end

   assign out_bucket_index = res_bucket_ff;
   assign out_slot_index   = res_slot_ff;
   assign out_table_full   = res_full_ff;

endmodule

@@ rtl/hbsa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsa_ctrl
// Sequencer for hashing, probing and commit; owns the handshakes.
// ----------------------------------------------------------------------------
module hbsa_ctrl import hbsa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD1,
      ST_MUL,
      ST_MOD2,
      ST_START,
      ST_PROBE,
      ST_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      out_free;
   logic      decide;

   assign out_free = !rsp_valid_ff || rsp_ready;
   // check stage has the answer: a hit, or the last bucket missed
   assign decide   = sts.chk_live && (sts.hit || sts.last);

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MOD1;
            end
         end
         ST_MOD1: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_last) state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_MOD2;
         end
         ST_MOD2: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_last) state_in = ST_START;
         end
         ST_START: begin
            cmd.probe_init = 1'b1;
            state_in       = ST_PROBE;
         end
         ST_PROBE: begin
            if (!decide) begin
               cmd.probe_adv = 1'b1;
            end else if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/hashed_bucket_slot_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_bucket_slot_allocator_core
// Linear-probing slot allocator over a bucketed table, one result per item.
// ----------------------------------------------------------------------------
// An item probes 1 to BUCKET_COUNT buckets before its result is decided; its
// commit, and so the next acceptance, waits while the previous result still
// waits for rsp ready when the new one is decided. The home bucket comes from
// a small remainder unit: the key modulo takes four folds of the upper key
// bits and one compare and subtract, the bucket modulo a reciprocal
// multiplication; probing then reads one bucket's occupancy per cycle from
// the single read port of the occupancy memory. The next request is taken
// while the previous result still waits in the output register. Occupancy
// resets at once through per-bucket valid flags; no clearing pass.
// ----------------------------------------------------------------------------
module hashed_bucket_slot_allocator_core import hbsa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   hbsa_req_if.sink  req_ch,
   hbsa_rsp_if.source rsp_ch
);

   cmd_type cmd;
   sts_type sts;

   hbsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hbsa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .in_opcode        (req_ch.opcode),
      .in_entry_key     (req_ch.entry_key),
      .in_companion_key (req_ch.companion_key),
      .out_bucket_index (rsp_ch.bucket_index),
      .out_slot_index   (rsp_ch.slot_index),
      .out_table_full   (rsp_ch.table_full)
   );

`ifndef NO_ASSERTIONS
   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result register overwritten");

   // commit only once the check stage holds a probed bucket
   a_commit_live: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.chk_live)
      else $error("commit without probed bucket");

   // commit raises the response valid on the next cycle
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_ch.valid)
      else $error("commit did not present a result");

   // no new request while an item is being probed
   a_probe_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.probe_adv |-> !req_ch.ready)
      else $error("request accepted during probe");
`endif

endmodule
